@@ rtl/tpvm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpvm_pkg
// Types, codes and helper functions shared by the triangle pair match blocks.
// ----------------------------------------------------------------------------
package tpvm_pkg;

  localparam int unsigned COUNT_W = 21;

  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [1:0]         vidx_t;
  typedef vidx_t [2:0]        perm_t;

  localparam perm_t PERM_IDENT = {2'd2, 2'd1, 2'd0};

  typedef enum logic [1:0] {
    REL_DISTANT = 2'd0,
    REL_VERTEX  = 2'd1,
    REL_EDGE    = 2'd2,
    REL_IDENT   = 2'd3
  } rel_e;

  typedef enum logic [1:0] {
    REG_DISTANT   = 2'd0,
    REG_VERTEX    = 2'd1,
    REG_EDGE      = 2'd2,
    REG_IDENTICAL = 2'd3
  } reg_e;

  localparam count_t DISTANT_RST   = count_t'(256);
  localparam count_t VERTEX_RST    = count_t'(1250);
  localparam count_t EDGE_RST      = count_t'(3750);
  localparam count_t IDENTICAL_RST = count_t'(3750);

  // point count registers
  typedef struct packed {
    count_t distant_pts;
    count_t vertex_pts;
    count_t edge_pts;
    count_t ident_pts;
  } cfg_t;

  // equality flags: ts[i][j] is t_i == s_j; tt/ss are {v1==v2, v0==v2, v0==v1}
  typedef struct packed {
    logic [2:0][2:0] ts;
    logic [2:0]      tt;
    logic [2:0]      ss;
  } match_t;

  // classification with shared-vertex prefix of both permutations
  typedef struct packed {
    rel_e       rel;
    logic       bad;
    logic [1:0] shared;
    perm_t      tp;
    perm_t      sp;
    logic [2:0] tt;
    logic [2:0] ss;
  } class_t;

  typedef struct packed {
    rel_e   rel;
    logic   bad;
    perm_t  tp;
    perm_t  sp;
    count_t points;
  } result_t;

  // equality of two local vertices of one triangle
  function automatic logic pair_eq(logic [2:0] e, vidx_t a, vidx_t b);
    logic r;
    r = 1'b1;
    if (a != b) begin
      if ((a == 2'd0 && b == 2'd1) || (a == 2'd1 && b == 2'd0)) begin
        r = e[0];
      end else if ((a == 2'd0 && b == 2'd2) || (a == 2'd2 && b == 2'd0)) begin
        r = e[1];
      end else begin
        r = e[2];
      end
    end
    return r;
  endfunction

  // append every vertex whose value is not yet listed
  function automatic perm_t fill_rest(logic [2:0] e, perm_t p_in, logic [1:0] filled);
    perm_t      p;
    logic [2:0] q;
    logic       found;
    p = p_in;
    q = {1'b0, filled};
    for (int i = 0; i < 3; i++) begin
      found = 1'b0;
      for (int j = 0; j < 3; j++) begin
        if (3'(j) < q && pair_eq(e, 2'(i), p[j])) begin
          found = 1'b1;
        end
      end
      if (!found) begin
        if (q < 3'd3) begin
          p[q[1:0]] = 2'(i);
        end
        q = q + 3'd1;
      end
    end
    return p;
  endfunction

endpackage

@@ rtl/triangle_pair_vertex_match_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_pair_vertex_match_unit
// Classifies a pair of triangles by shared vertices and orders their vertices.
// ----------------------------------------------------------------------------
// Usage: a pair is taken on every cycle that start is high (busy stays low, so
// a new pair may follow in the very next cycle). Its result appears on the
// result ports, after the three register stages, for one cycle with done_o
// high; there is no way to hold it off, so the receiver must take it then.
// The three register stages are: index compares, match count and
// shared-vertex ordering, then fill of the remaining vertices with the point
// count lookup. Point count registers sit at byte addresses 0, 4, 8 and 12
// of the APB port and should only be written while no pair is in flight.
// ----------------------------------------------------------------------------
module triangle_pair_vertex_match_unit #(
  parameter int unsigned INDEX_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command side
  input  logic                          start,
  output logic                          busy,
  input  logic [INDEX_WIDTH-1:0]        t_vertex0_i,
  input  logic [INDEX_WIDTH-1:0]        t_vertex1_i,
  input  logic [INDEX_WIDTH-1:0]        t_vertex2_i,
  input  logic [INDEX_WIDTH-1:0]        s_vertex0_i,
  input  logic [INDEX_WIDTH-1:0]        s_vertex1_i,
  input  logic [INDEX_WIDTH-1:0]        s_vertex2_i,
  // result side
  output logic                          done_o,
  output logic [1:0]                    relation_o,
  output logic                          bad_pair_o,
  output logic [1:0]                    t_perm0_o,
  output logic [1:0]                    t_perm1_o,
  output logic [1:0]                    t_perm2_o,
  output logic [1:0]                    s_perm0_o,
  output logic [1:0]                    s_perm1_o,
  output logic [1:0]                    s_perm2_o,
  output logic [tpvm_pkg::COUNT_W-1:0]  point_count_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  tpvm_pkg::cfg_t    cfg;
  tpvm_pkg::match_t  match;
  tpvm_pkg::class_t  cls;
  tpvm_pkg::result_t res;
  logic              accept;
  logic              cmp_valid;
  logic              cls_valid;

  // the pipeline never stalls, so a beat is always welcome
  assign busy   = 1'b0;
  assign accept = start && !busy;

  tpvm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // stage one: nine cross compares plus repeats within each triangle
  tpvm_compare #(
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_compare (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (accept),
    .t_vertex0_i (t_vertex0_i),
    .t_vertex1_i (t_vertex1_i),
    .t_vertex2_i (t_vertex2_i),
    .s_vertex0_i (s_vertex0_i),
    .s_vertex1_i (s_vertex1_i),
    .s_vertex2_i (s_vertex2_i),
    .valid_o     (cmp_valid),
    .match_o     (match)
  );

  // stage two: class from the match count, shared vertices first
  tpvm_classify u_classify (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cmp_valid),
    .match_i (match),
    .valid_o (cls_valid),
    .class_o (cls)
  );

  // stage three: remaining vertices in index order, point count lookup
  tpvm_order u_order (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (cls_valid),
    .class_i  (cls),
    .cfg_i    (cfg),
    .valid_o  (done_o),
    .result_o (res)
  );

  // result beat straight from the last stage registers
  assign relation_o    = res.rel;
  assign bad_pair_o    = res.bad;
  assign t_perm0_o     = res.tp[0];
  assign t_perm1_o     = res.tp[1];
  assign t_perm2_o     = res.tp[2];
  assign s_perm0_o     = res.sp[0];
  assign s_perm1_o     = res.sp[1];
  assign s_perm2_o     = res.sp[2];
  assign point_count_o = res.points;

  // every accepted beat comes out after the compare, classify and order registers
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##3 done_o)
    else $error("accepted beat did not produce a result");

  // no result without an accepted beat that went through the pipeline
  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 3))
    else $error("result strobe without a matching beat");

  // degenerate pair reports distant class with no points
  a_bad_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && bad_pair_o) |->
    (point_count_o == '0 && relation_o == tpvm_pkg::REL_DISTANT))
    else $error("bad pair with nonzero class or points");

  // distant, identical and bad pairs keep identity orders
  a_identity : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (bad_pair_o || relation_o == tpvm_pkg::REL_DISTANT ||
                relation_o == tpvm_pkg::REL_IDENT)) |->
    (t_perm0_o == 2'd0 && t_perm1_o == 2'd1 && t_perm2_o == 2'd2 &&
     s_perm0_o == 2'd0 && s_perm1_o == 2'd1 && s_perm2_o == 2'd2))
    else $error("non identity order for distant or identical pair");

endmodule

@@ rtl/tpvm_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpvm_regs
// APB register file holding the four point count registers.
// ----------------------------------------------------------------------------
module tpvm_regs (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [3:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready,
  output tpvm_pkg::cfg_t  cfg_o
);

  tpvm_pkg::cfg_t cfg_q, cfg_d;
  tpvm_pkg::reg_e sel;
  tpvm_pkg::count_t rd_val;
  logic wr_en;

  assign sel    = tpvm_pkg::reg_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (sel)
        tpvm_pkg::REG_DISTANT:   cfg_d.distant_pts = pwdata[tpvm_pkg::COUNT_W-1:0];
        tpvm_pkg::REG_VERTEX:    cfg_d.vertex_pts  = pwdata[tpvm_pkg::COUNT_W-1:0];
        tpvm_pkg::REG_EDGE:      cfg_d.edge_pts    = pwdata[tpvm_pkg::COUNT_W-1:0];
        tpvm_pkg::REG_IDENTICAL: cfg_d.ident_pts   = pwdata[tpvm_pkg::COUNT_W-1:0];
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (sel)
      tpvm_pkg::REG_DISTANT:   rd_val = cfg_q.distant_pts;
      tpvm_pkg::REG_VERTEX:    rd_val = cfg_q.vertex_pts;
      tpvm_pkg::REG_EDGE:      rd_val = cfg_q.edge_pts;
      tpvm_pkg::REG_IDENTICAL: rd_val = cfg_q.ident_pts;
      default:                 rd_val = '0;
    endcase
  end

  assign prdata = {{(32 - tpvm_pkg::COUNT_W){1'b0}}, rd_val};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.distant_pts <= tpvm_pkg::DISTANT_RST;
      cfg_q.vertex_pts  <= tpvm_pkg::VERTEX_RST;
      cfg_q.edge_pts    <= tpvm_pkg::EDGE_RST;
      cfg_q.ident_pts   <= tpvm_pkg::IDENTICAL_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/tpvm_compare.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpvm_compare
// Stage one: all index equality compares, registered as flags.
// ----------------------------------------------------------------------------
module tpvm_compare #(
  parameter int unsigned INDEX_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [INDEX_WIDTH-1:0] t_vertex0_i,
  input  logic [INDEX_WIDTH-1:0] t_vertex1_i,
  input  logic [INDEX_WIDTH-1:0] t_vertex2_i,
  input  logic [INDEX_WIDTH-1:0] s_vertex0_i,
  input  logic [INDEX_WIDTH-1:0] s_vertex1_i,
  input  logic [INDEX_WIDTH-1:0] s_vertex2_i,
  output logic                   valid_o,
  output tpvm_pkg::match_t       match_o
);

  logic [2:0][INDEX_WIDTH-1:0] tv, sv;
  tpvm_pkg::match_t match_d, match_q;
  logic valid_q;

  assign tv = {t_vertex2_i, t_vertex1_i, t_vertex0_i};
  assign sv = {s_vertex2_i, s_vertex1_i, s_vertex0_i};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        match_d.ts[i][j] = (tv[i] == sv[j]);
      end
    end
    match_d.tt = {tv[1] == tv[2], tv[0] == tv[2], tv[0] == tv[1]};
    match_d.ss = {sv[1] == sv[2], sv[0] == sv[2], sv[0] == sv[1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      match_q <= match_d;
    end
  end

  assign valid_o = valid_q;
  assign match_o = match_q;

endmodule

@@ rtl/tpvm_classify.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpvm_classify
// Stage two: match count, class and the shared-vertex head of both orders.
// ----------------------------------------------------------------------------
module tpvm_classify (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  tpvm_pkg::match_t  match_i,
  output logic              valid_o,
  output tpvm_pkg::class_t  class_o
);

  tpvm_pkg::class_t class_d, class_q;
  logic [3:0] cnt;
  logic       hit;
  logic       valid_q;

  assign cnt = 4'($countones(match_i.ts));

  always_comb begin
    class_d.tt     = match_i.tt;
    class_d.ss     = match_i.ss;
    class_d.tp     = tpvm_pkg::PERM_IDENT;
    class_d.sp     = tpvm_pkg::PERM_IDENT;
    class_d.shared = 2'd0;
    class_d.bad    = 1'b0;
    class_d.rel    = tpvm_pkg::REL_DISTANT;
    hit            = 1'b0;
    if (cnt == 4'd3) begin
      class_d.rel = tpvm_pkg::REL_IDENT;
    end else if (cnt > 4'd3) begin
      class_d.bad = 1'b1;
    end else if (cnt != 4'd0) begin
      class_d.rel = tpvm_pkg::rel_e'(cnt[1:0]);
      // each test vertex with a match, paired with its first trial match
      for (int i = 0; i < 3; i++) begin
        hit = 1'b0;
        for (int j = 0; j < 3; j++) begin
          if (!hit && match_i.ts[i][j]) begin
            hit = 1'b1;
            if (class_d.shared != 2'd3) begin
              class_d.tp[class_d.shared] = 2'(i);
              class_d.sp[class_d.shared] = 2'(j);
            end
          end
        end
        if (hit) begin
          class_d.shared = class_d.shared + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      class_q <= class_d;
    end
  end

  assign valid_o = valid_q;
  assign class_o = class_q;

endmodule

@@ rtl/tpvm_order.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpvm_order
// Stage three: fill the remaining vertices and pick the point count.
// ----------------------------------------------------------------------------
module tpvm_order (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  tpvm_pkg::class_t  class_i,
  input  tpvm_pkg::cfg_t    cfg_i,
  output logic              valid_o,
  output tpvm_pkg::result_t result_o
);

  tpvm_pkg::result_t res_d, res_q;
  logic valid_q;

  always_comb begin
    res_d.rel = class_i.rel;
    res_d.bad = class_i.bad;
    res_d.tp  = tpvm_pkg::PERM_IDENT;
    res_d.sp  = tpvm_pkg::PERM_IDENT;
    case (class_i.rel)
      tpvm_pkg::REL_DISTANT: res_d.points = cfg_i.distant_pts;
      tpvm_pkg::REL_VERTEX:  res_d.points = cfg_i.vertex_pts;
      tpvm_pkg::REL_EDGE:    res_d.points = cfg_i.edge_pts;
      tpvm_pkg::REL_IDENT:   res_d.points = cfg_i.ident_pts;
      default:               res_d.points = '0;
    endcase
    if (class_i.bad) begin
      res_d.points = '0;
    end else if (class_i.rel == tpvm_pkg::REL_VERTEX || class_i.rel == tpvm_pkg::REL_EDGE) begin
      res_d.tp = tpvm_pkg::fill_rest(class_i.tt, class_i.tp, class_i.shared);
      res_d.sp = tpvm_pkg::fill_rest(class_i.ss, class_i.sp, class_i.shared);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;

endmodule

@@ test/tb_triangle_pair_vertex_match_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_pair_vertex_match_unit
// Self-checking bench for the triangle pair vertex match unit.
// ----------------------------------------------------------------------------
// A short table of hand-picked pairs comes first: disjoint, identical and
// degenerate pairs against typed results, and shared vertex or shared edge
// pairs with repeated indices against the built-in classifier. Three random
// phases follow, each under its own set of point counts (both range limits
// reached on every register). Random pairs are mostly built to share one
// vertex, an edge or all three, or drawn from a tiny index range to force
// repeats and over-counted matches or from extreme values; the rest is noise.
// Every result beat is compared field by field with the oldest expected beat.
// ----------------------------------------------------------------------------
module tb_triangle_pair_vertex_match_unit;

  localparam int unsigned       CLK_PERIOD  = 12;
  localparam int unsigned       RAND_PAIRS  = 600;   // per random phase
  localparam int unsigned       CYCLE_LIMIT = 200000;
  localparam tpvm_pkg::count_t  COUNT_LOW   = tpvm_pkg::count_t'(1);
  localparam tpvm_pkg::count_t  COUNT_HIGH  = tpvm_pkg::count_t'(1048576);

  typedef logic [31:0] index_t;

  typedef struct packed {
    index_t [2:0] tv;
    index_t [2:0] sv;
  } tri_pair_t;

  // one directed row; rel/bad/points only mean something when typed is set
  typedef struct packed {
    index_t           t0, t1, t2;
    index_t           s0, s1, s2;
    logic             typed;
    tpvm_pkg::rel_e   rel;
    logic             bad;
    tpvm_pkg::count_t points;
  } pair_row_t;

  localparam int unsigned N_ROWS = 20;

  pair_row_t directed_rows [N_ROWS] = '{
    // disjoint, small and large indices
    '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5,
      1'b1, tpvm_pkg::REL_DISTANT, 1'b0, tpvm_pkg::DISTANT_RST},
    '{32'hFFFFFFFF, 32'hFFFFFFFE, 32'hFFFFFFFD, 32'h0, 32'h1, 32'h2,
      1'b1, tpvm_pkg::REL_DISTANT, 1'b0, tpvm_pkg::DISTANT_RST},
    // all six indices equal: nine matches
    '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
      1'b1, tpvm_pkg::REL_DISTANT, 1'b1, tpvm_pkg::count_t'(0)},
    '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
      1'b1, tpvm_pkg::REL_DISTANT, 1'b1, tpvm_pkg::count_t'(0)},
    // identical triangles, same and rotated order
    '{32'd10, 32'd20, 32'd30, 32'd10, 32'd20, 32'd30,
      1'b1, tpvm_pkg::REL_IDENT, 1'b0, tpvm_pkg::IDENTICAL_RST},
    '{32'd10, 32'd20, 32'd30, 32'd30, 32'd10, 32'd20,
      1'b1, tpvm_pkg::REL_IDENT, 1'b0, tpvm_pkg::IDENTICAL_RST},
    // repeats that still add up to three matches
    '{32'd1, 32'd1, 32'd1, 32'd1, 32'd2, 32'd3,
      1'b1, tpvm_pkg::REL_IDENT, 1'b0, tpvm_pkg::IDENTICAL_RST},
    '{32'd0, 32'd1, 32'd2, 32'd1, 32'd1, 32'd1,
      1'b1, tpvm_pkg::REL_IDENT, 1'b0, tpvm_pkg::IDENTICAL_RST},
    // repeats giving more than three matches
    '{32'd1, 32'd1, 32'd2, 32'd1, 32'd1, 32'd5,
      1'b1, tpvm_pkg::REL_DISTANT, 1'b1, tpvm_pkg::count_t'(0)},
    '{32'd3, 32'd3, 32'd9, 32'd3, 32'd3, 32'd9,
      1'b1, tpvm_pkg::REL_DISTANT, 1'b1, tpvm_pkg::count_t'(0)},
    // one shared vertex in various places
    '{32'd1, 32'd2, 32'd3, 32'd7, 32'd8, 32'd1,
      1'b0, tpvm_pkg::REL_DISTANT, 1'b0, tpvm_pkg::count_t'(0)},
    '{32'd10, 32'd11, 32'd12, 32'd12, 32'd13, 32'd14,
      1'b0, tpvm_pkg::REL_DISTANT, 1'b0, tpvm_pkg::count_t'(0)},
    '{32'hFFFFFFFF, 32'hFFFFFFFE, 32'h0, 32'h0, 32'h80000000, 32'h7FFFFFFF,
      1'b0, tpvm_pkg::REL_DISTANT, 1'b0, tpvm_pkg::count_t'(0)},
    '{32'hAAAAAAAA, 32'h55555555, 32'hFFFF0000, 32'h0000FFFF, 32'h55555555, 32'h12345678,
      1'b0, tpvm_pkg::REL_DISTANT, 1'b0, tpvm_pkg::count_t'(0)},
    // shared edge, straight and reversed
    '{32'd5, 32'd6, 32'd7, 32'd6, 32'd9, 32'd5,
      1'b0, tpvm_pkg::REL_DISTANT, 1'b0, tpvm_pkg::count_t'(0)},
    '{32'd10, 32'd11, 32'd12, 32'd12, 32'd11, 32'd0,
      1'b0, tpvm_pkg::REL_DISTANT, 1'b0, tpvm_pkg::count_t'(0)},
    // repeated index inside one triangle, two matches
    '{32'd4, 32'd4, 32'd5, 32'd4, 32'd8, 32'd9,
      1'b0, tpvm_pkg::REL_DISTANT, 1'b0, tpvm_pkg::count_t'(0)},
    '{32'd1, 32'd2, 32'd3, 32'd2, 32'd2, 32'd9,
      1'b0, tpvm_pkg::REL_DISTANT, 1'b0, tpvm_pkg::count_t'(0)},
    '{32'd1, 32'd1, 32'd2, 32'd2, 32'd2, 32'd7,
      1'b0, tpvm_pkg::REL_DISTANT, 1'b0, tpvm_pkg::count_t'(0)},
    '{32'd7, 32'd8, 32'd7, 32'd9, 32'd7, 32'd9,
      1'b0, tpvm_pkg::REL_DISTANT, 1'b0, tpvm_pkg::count_t'(0)}
  };

  logic                          clk_i;
  logic                          rst_ni;
  logic                          start;
  logic                          busy;
  index_t                        t_vertex0_i, t_vertex1_i, t_vertex2_i;
  index_t                        s_vertex0_i, s_vertex1_i, s_vertex2_i;
  logic                          done_o;
  logic [1:0]                    relation_o;
  logic                          bad_pair_o;
  logic [1:0]                    t_perm0_o, t_perm1_o, t_perm2_o;
  logic [1:0]                    s_perm0_o, s_perm1_o, s_perm2_o;
  logic [tpvm_pkg::COUNT_W-1:0]  point_count_o;
  logic                          psel, penable, pwrite;
  logic [3:0]                    paddr;
  logic [31:0]                   pwdata;
  logic [31:0]                   prdata;
  logic                          pready;

  // local copy of the point count registers
  tpvm_pkg::count_t  point_counts [4];
  // expected result beats, oldest first
  tpvm_pkg::result_t pending_results [$];
  int unsigned       sender_idle_pct;
  int unsigned       fail_count;
  int unsigned       cycle_count;

  triangle_pair_vertex_match_unit #(
    .INDEX_WIDTH(32)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .t_vertex0_i  (t_vertex0_i),
    .t_vertex1_i  (t_vertex1_i),
    .t_vertex2_i  (t_vertex2_i),
    .s_vertex0_i  (s_vertex0_i),
    .s_vertex1_i  (s_vertex1_i),
    .s_vertex2_i  (s_vertex2_i),
    .done_o       (done_o),
    .relation_o   (relation_o),
    .bad_pair_o   (bad_pair_o),
    .t_perm0_o    (t_perm0_o),
    .t_perm1_o    (t_perm1_o),
    .t_perm2_o    (t_perm2_o),
    .s_perm0_o    (s_perm0_o),
    .s_perm1_o    (s_perm1_o),
    .s_perm2_o    (s_perm2_o),
    .point_count_o(point_count_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // classifier
  // --------------------------------------------------------------------------

  // append each vertex whose index is not yet among the listed positions;
  // writes past the third position are lost but still advance the fill level
  function automatic tpvm_pkg::perm_t append_unlisted(index_t [2:0] v, tpvm_pkg::perm_t p,
                                                      int unsigned filled);
    int unsigned level;
    logic        listed;
    level = filled;
    for (int i = 0; i < 3; i++) begin
      listed = 1'b0;
      for (int j = 0; j < 3; j++) begin
        if (j < level && v[i] == v[p[j]]) begin
          listed = 1'b1;
        end
      end
      if (!listed) begin
        if (level < 3) begin
          p[level] = tpvm_pkg::vidx_t'(i);
        end
        level++;
      end
    end
    return p;
  endfunction

  function automatic tpvm_pkg::result_t classify_pair(tri_pair_t p);
    tpvm_pkg::result_t r;
    int unsigned       hits;
    int unsigned       n_shared;
    logic              hit;
    r.rel    = tpvm_pkg::REL_DISTANT;
    r.bad    = 1'b0;
    r.tp     = tpvm_pkg::PERM_IDENT;
    r.sp     = tpvm_pkg::PERM_IDENT;
    r.points = '0;
    hits     = 0;
    n_shared = 0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (p.tv[i] == p.sv[j]) begin
          hits++;
        end
      end
    end
    if (hits == 0) begin
      r.points = point_counts[tpvm_pkg::REG_DISTANT];
    end else if (hits == 3) begin
      r.rel    = tpvm_pkg::REL_IDENT;
      r.points = point_counts[tpvm_pkg::REG_IDENTICAL];
    end else if (hits > 3) begin
      // degenerate pair: error flag, identity orders, no points
      r.bad = 1'b1;
    end else begin
      r.rel    = (hits == 1) ? tpvm_pkg::REL_VERTEX : tpvm_pkg::REL_EDGE;
      r.points = (hits == 1) ? point_counts[tpvm_pkg::REG_VERTEX]
                             : point_counts[tpvm_pkg::REG_EDGE];
      // shared vertices lead, each with its first matching trial vertex
      for (int i = 0; i < 3; i++) begin
        hit = 1'b0;
        for (int j = 0; j < 3; j++) begin
          if (!hit && p.tv[i] == p.sv[j]) begin
            hit              = 1'b1;
            r.tp[n_shared]   = tpvm_pkg::vidx_t'(i);
            r.sp[n_shared]   = tpvm_pkg::vidx_t'(j);
            n_shared++;
          end
        end
      end
      r.tp = append_unlisted(p.tv, r.tp, n_shared);
      r.sp = append_unlisted(p.sv, r.sp, n_shared);
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------

  function automatic index_t pick_extreme();
    int unsigned sel;
    sel = $urandom_range(2);
    return (sel == 0) ? '0 : (sel == 1) ? '1 : index_t'($urandom);
  endfunction

  // mostly pairs built to share vertices, some tiny-range, extreme-value and plain noise
  function automatic tri_pair_t make_pair();
    tri_pair_t   p;
    int unsigned mode, i0, i1, j0, j1, rot;
    index_t      swap_tmp;
    for (int k = 0; k < 3; k++) begin
      p.tv[k] = $urandom;
      p.sv[k] = $urandom;
    end
    mode = $urandom_range(9);
    case (mode)
      1, 2: begin
        p.sv[$urandom_range(2)] = p.tv[$urandom_range(2)];
      end
      3, 4: begin
        i0 = $urandom_range(2);
        i1 = (i0 + 1 + $urandom_range(1)) % 3;
        j0 = $urandom_range(2);
        j1 = (j0 + 1 + $urandom_range(1)) % 3;
        p.sv[j0] = p.tv[i0];
        p.sv[j1] = p.tv[i1];
      end
      5: begin
        rot = $urandom_range(2);
        for (int k = 0; k < 3; k++) begin
          p.sv[k] = p.tv[(k + rot) % 3];
        end
        if ($urandom_range(1) == 1) begin
          swap_tmp = p.sv[0];
          p.sv[0]  = p.sv[1];
          p.sv[1]  = swap_tmp;
        end
      end
      6, 7: begin
        // tiny index range: repeats inside a triangle and over-counts
        for (int k = 0; k < 3; k++) begin
          p.tv[k] = index_t'($urandom_range(3));
          p.sv[k] = index_t'($urandom_range(3));
        end
      end
      8: begin
        for (int k = 0; k < 3; k++) begin
          p.tv[k] = pick_extreme();
          p.sv[k] = pick_extreme();
        end
      end
      default: begin
        // noise, nearly always a disjoint pair
      end
    endcase
    return p;
  endfunction

  // one command beat, after a random number of idle cycles
  task automatic send_pair(tri_pair_t p, logic typed, tpvm_pkg::result_t typed_result);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start       <= 1'b1;
    t_vertex0_i <= p.tv[0];
    t_vertex1_i <= p.tv[1];
    t_vertex2_i <= p.tv[2];
    s_vertex0_i <= p.sv[0];
    s_vertex1_i <= p.sv[1];
    s_vertex2_i <= p.sv[2];
    do @(posedge clk_i); while (busy);
    pending_results.push_back(typed ? typed_result : classify_pair(p));
  endtask

  // stop sending and let every pair in flight come out
  task automatic drain_pairs();
    start <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // apb transfer: setup phase, then access until pready, then back to idle
  task automatic apb_transfer(tpvm_pkg::reg_e r, logic wr, index_t wdata,
                              output index_t rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {r, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // write all four point counts, then read each one back
  task automatic program_counts(tpvm_pkg::count_t vals [4]);
    index_t rd;
    for (int r = 0; r < 4; r++) begin
      apb_transfer(tpvm_pkg::reg_e'(r), 1'b1, index_t'(vals[r]), rd);
      point_counts[r] = vals[r];
    end
    for (int r = 0; r < 4; r++) begin
      apb_transfer(tpvm_pkg::reg_e'(r), 1'b0, '0, rd);
      if (rd[tpvm_pkg::COUNT_W-1:0] !== point_counts[r]) begin
        $display("%0t: point count register %0d readback, expected %0d, actual %0d",
                 $time, r, point_counts[r], rd[tpvm_pkg::COUNT_W-1:0]);
        fail_count++;
      end
    end
  endtask

  initial begin
    tri_pair_t         p;
    tpvm_pkg::result_t typed_result;
    tpvm_pkg::count_t  phase_counts [4];
    int unsigned       phase_idle [3];
    rst_ni          = 1'b0;
    start           = 1'b0;
    t_vertex0_i     = '0;
    t_vertex1_i     = '0;
    t_vertex2_i     = '0;
    s_vertex0_i     = '0;
    s_vertex1_i     = '0;
    s_vertex2_i     = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    fail_count      = 0;
    sender_idle_pct = 34;
    phase_idle      = '{34, 69, 0};
    point_counts[tpvm_pkg::REG_DISTANT]   = tpvm_pkg::DISTANT_RST;
    point_counts[tpvm_pkg::REG_VERTEX]    = tpvm_pkg::VERTEX_RST;
    point_counts[tpvm_pkg::REG_EDGE]      = tpvm_pkg::EDGE_RST;
    point_counts[tpvm_pkg::REG_IDENTICAL] = tpvm_pkg::IDENTICAL_RST;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table under reset point counts
    foreach (directed_rows[k]) begin
      p.tv = {directed_rows[k].t2, directed_rows[k].t1, directed_rows[k].t0};
      p.sv = {directed_rows[k].s2, directed_rows[k].s1, directed_rows[k].s0};
      typed_result.rel    = directed_rows[k].rel;
      typed_result.bad    = directed_rows[k].bad;
      typed_result.tp     = tpvm_pkg::PERM_IDENT;
      typed_result.sp     = tpvm_pkg::PERM_IDENT;
      typed_result.points = directed_rows[k].points;
      send_pair(p, directed_rows[k].typed, typed_result);
    end

    // random phases, each with its own point counts and sender idling
    for (int ph = 0; ph < 3; ph++) begin
      drain_pairs();
      case (ph)
        0:       phase_counts = '{COUNT_LOW, COUNT_HIGH, COUNT_LOW, COUNT_HIGH};
        1:       phase_counts = '{COUNT_HIGH, COUNT_LOW, COUNT_HIGH, COUNT_LOW};
        default: begin
          for (int r = 0; r < 4; r++) begin
            phase_counts[r] = tpvm_pkg::count_t'($urandom_range(COUNT_HIGH, COUNT_LOW));
          end
        end
      endcase
      program_counts(phase_counts);
      sender_idle_pct = phase_idle[ph];
      repeat (RAND_PAIRS) begin
        send_pair(make_pair(), 1'b0, typed_result);
      end
    end

    drain_pairs();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // result checking
  // --------------------------------------------------------------------------

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // the receiver cannot stall, so every done beat is taken at its edge
  always @(posedge clk_i) begin
    tpvm_pkg::result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, actual relation %0d points %0d",
                 $time, relation_o, point_count_o);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("relation",    want.rel,    relation_o);
        check_field("bad_pair",    want.bad,    bad_pair_o);
        check_field("t_perm0",     want.tp[0],  t_perm0_o);
        check_field("t_perm1",     want.tp[1],  t_perm1_o);
        check_field("t_perm2",     want.tp[2],  t_perm2_o);
        check_field("s_perm0",     want.sp[0],  s_perm0_o);
        check_field("s_perm1",     want.sp[1],  s_perm1_o);
        check_field("s_perm2",     want.sp[2],  s_perm2_o);
        check_field("point_count", want.points, point_count_o);
      end
    end
  end

  // watchdog
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run did not finish, %0d beats still expected",
               $time, pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule
